// File: src/dllm_pkg.sv
// dllm_pkg: op codes and fixed field widths for the linked list manager
// no dependencies; imported by the top level
`default_nettype none

package dllm_pkg;

	// widths of the node and count fields on the ports
	localparam int NODE_W  = 6;
	localparam int COUNT_W = 7;

	// op codes carried by the op field
	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_INS_AFTER  = 3'd2,
		OP_INS_BEFORE = 3'd3,
		OP_POP_FRONT  = 3'd4,
		OP_POP_BACK   = 3'd5,
		OP_REMOVE     = 3'd6,
		OP_QUERY      = 3'd7
	} op_t;

endpackage

`default_nettype wire

// File: src/dllm_link_ram.sv
// dllm_link_ram: one link store, one write port and one registered read port
// no dependencies; instantiated twice by the top level (next and prev links)
`default_nettype none

module dllm_link_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 7,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered from the address when re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/doubly_linked_list_manager_unit.sv
// doubly_linked_list_manager_unit: top level of the linked list manager
// depends on dllm_pkg and dllm_link_ram
//
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+---------------------------
//  input   | in_valid, in_stall, op, node, anchor     | in_valid && !in_stall
//  output  | out_valid, out_stall, popped_node ...    | out_valid && !out_stall
//          |   prev_valid (one result per input item) |
//
// Every item passes through four steps: accept with link read, first link write,
// second link write, result load. The two link memories each have one write
// port, which sets the two write steps.
// After reset both link memories are cleared to null, one entry per cycle, so
// no input is taken until the clearing pass is done.
// A held result in the output register does not block the next item; only the
// result load waits for the output register to empty.
`default_nettype none

module doubly_linked_list_manager_unit #(
	parameter int NODES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     op,
	input  logic [dllm_pkg::NODE_W-1:0]    node,
	input  logic [dllm_pkg::NODE_W-1:0]    anchor,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dllm_pkg::NODE_W-1:0]    popped_node,
	output logic                           popped_valid,
	output logic [dllm_pkg::NODE_W-1:0]    head_node,
	output logic [dllm_pkg::NODE_W-1:0]    tail_node,
	output logic                           list_empty,
	output logic [dllm_pkg::COUNT_W-1:0]   count,
	output logic [dllm_pkg::NODE_W-1:0]    next_node,
	output logic                           next_valid,
	output logic [dllm_pkg::NODE_W-1:0]    prev_node,
	output logic                           prev_valid
);

	import dllm_pkg::*;

	// link width holds a slot number or null, index width addresses a slot
	localparam int LW  = $clog2(NODES + 1);
	localparam int IW  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int XW  = LW + NODE_W;
	localparam logic [LW-1:0] NIL = LW'(NODES);
	localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_W1,
		ST_W2,
		ST_DONE
	} state_t;

	function automatic logic is_slot(input logic [LW-1:0] v);
		return v < NIL;
	endfunction

	function automatic logic [IW-1:0] idx(input logic [LW-1:0] v);
		return is_slot(v) ? IW'(v) : '0;
	endfunction

	function automatic logic [NODE_W-1:0] to_node(input logic [LW-1:0] v);
		logic [XW-1:0] e;
		e = {{NODE_W{1'b0}}, v};
		return is_slot(v) ? e[NODE_W-1:0] : '0;
	endfunction

	state_t            state_q;
	logic [IW-1:0]     clr_q;
	logic [LW-1:0]     head_q, tail_q;
	logic [COUNT_W-1:0] count_q;

	op_t               op_q;
	logic [LW-1:0]     n_q, a_q;
	logic              n_ok_q, a_ok_q;

	logic              w2_nx_we_q, w2_pv_we_q;
	logic [IW-1:0]     w2_nx_wa_q, w2_pv_wa_q;
	logic [LW-1:0]     w2_nx_wd_q, w2_pv_wd_q;

	logic [NODE_W-1:0] popped_q, qn_q, qp_q;
	logic              popped_v_q, qn_v_q, qp_v_q;
	logic              out_valid_q;

	// input side decode
	op_t               op_in;
	logic [LW-1:0]     node_l, anchor_l;
	logic              n_ok_in, a_ok_in, take;

	// link memory ports
	logic              nx_we, pv_we;
	logic [IW-1:0]     nx_wa, pv_wa, nx_ra, pv_ra;
	logic [LW-1:0]     nx_wd, pv_wd, nx_rd, pv_rd;

	// first write cycle results
	logic              w1_nx_we, w1_pv_we, w2_nx_we, w2_pv_we;
	logic [IW-1:0]     w1_nx_wa, w1_pv_wa, w2_nx_wa, w2_pv_wa;
	logic [LW-1:0]     w1_nx_wd, w1_pv_wd, w2_nx_wd, w2_pv_wd;
	logic [LW-1:0]     head_d, tail_d, t_node;
	logic [COUNT_W-1:0] count_d;
	logic [NODE_W-1:0] popped_d, qn_d, qp_d;
	logic              popped_v_d, qn_v_d, qp_v_d, unlink_ok;

	assign op_in    = op_t'(op);
	assign node_l   = LW'(node);
	assign anchor_l = LW'(anchor);
	assign n_ok_in  = {{LW{1'b0}}, node} < XW'(NODES);
	assign a_ok_in  = {{LW{1'b0}}, anchor} < XW'(NODES);
	assign in_stall = (state_q != ST_IDLE);
	assign take     = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// read addresses, issued on the input transfer
	always_comb begin
		unique case (op_in)
			OP_INS_AFTER: begin
				nx_ra = idx(anchor_l);
				pv_ra = idx(node_l);
			end
			OP_INS_BEFORE: begin
				nx_ra = idx(node_l);
				pv_ra = idx(anchor_l);
			end
			OP_POP_FRONT: begin
				nx_ra = idx(head_q);
				pv_ra = idx(head_q);
			end
			OP_POP_BACK: begin
				nx_ra = idx(tail_q);
				pv_ra = idx(tail_q);
			end
			default: begin
				nx_ra = idx(node_l);
				pv_ra = idx(node_l);
			end
		endcase
	end

	// link updates and results of the first write cycle
	always_comb begin
		w1_nx_we = 1'b0;
		w1_nx_wa = idx(n_q);
		w1_nx_wd = NIL;
		w1_pv_we = 1'b0;
		w1_pv_wa = idx(n_q);
		w1_pv_wd = NIL;
		w2_nx_we = 1'b0;
		w2_nx_wa = idx(n_q);
		w2_nx_wd = NIL;
		w2_pv_we = 1'b0;
		w2_pv_wa = idx(n_q);
		w2_pv_wd = NIL;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		popped_d   = '0;
		popped_v_d = 1'b0;
		qn_d       = '0;
		qn_v_d     = 1'b0;
		qp_d       = '0;
		qp_v_d     = 1'b0;
		t_node     = n_q;
		unlink_ok  = n_ok_q;
		if (op_q == OP_POP_FRONT) begin
			t_node    = head_q;
			unlink_ok = is_slot(head_q);
		end else if (op_q == OP_POP_BACK) begin
			t_node    = tail_q;
			unlink_ok = is_slot(tail_q);
		end
		unique case (op_q)
			OP_PUSH_FRONT: begin
				if (n_ok_q) begin
					w1_nx_we = 1'b1;
					w1_pv_we = 1'b1;
					if (is_slot(head_q)) begin
						w1_pv_wa = idx(head_q);
						w1_pv_wd = n_q;
						w1_nx_wd = head_q;
						w2_pv_we = 1'b1;
					end else begin
						tail_d = n_q;
					end
					head_d  = n_q;
					count_d = count_q + COUNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (n_ok_q) begin
					w1_nx_we = 1'b1;
					w1_pv_we = 1'b1;
					if (is_slot(tail_q)) begin
						w1_nx_wa = idx(tail_q);
						w1_nx_wd = n_q;
						w1_pv_wd = tail_q;
						w2_nx_we = 1'b1;
					end else begin
						head_d = n_q;
					end
					tail_d  = n_q;
					count_d = count_q + COUNT_W'(1);
				end
			end
			OP_INS_AFTER: begin
				if (n_ok_q && a_ok_q) begin
					// new node takes the anchor's successor, then neighbors point at it
					w1_nx_we = 1'b1;
					w1_nx_wd = nx_rd;
					w1_pv_we = 1'b1;
					w1_pv_wd = a_q;
					if (is_slot(nx_rd)) begin
						w2_pv_we = 1'b1;
						w2_pv_wa = idx(nx_rd);
						w2_pv_wd = n_q;
					end else begin
						tail_d = n_q;
					end
					w2_nx_we = 1'b1;
					w2_nx_wa = idx(a_q);
					w2_nx_wd = n_q;
					count_d  = count_q + COUNT_W'(1);
				end
			end
			OP_INS_BEFORE: begin
				if (n_ok_q && a_ok_q) begin
					w1_pv_we = 1'b1;
					w1_pv_wd = pv_rd;
					w1_nx_we = 1'b1;
					w1_nx_wd = a_q;
					if (is_slot(pv_rd)) begin
						w2_nx_we = 1'b1;
						w2_nx_wa = idx(pv_rd);
						w2_nx_wd = n_q;
					end else begin
						head_d = n_q;
					end
					w2_pv_we = 1'b1;
					w2_pv_wa = idx(a_q);
					w2_pv_wd = n_q;
					count_d  = count_q + COUNT_W'(1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
				if (unlink_ok) begin
					// bridge the neighbors of the node being taken off
					if (is_slot(nx_rd)) begin
						w1_pv_we = 1'b1;
						w1_pv_wa = idx(nx_rd);
						w1_pv_wd = pv_rd;
					end
					if (is_slot(pv_rd)) begin
						w1_nx_we = 1'b1;
						w1_nx_wa = idx(pv_rd);
						w1_nx_wd = nx_rd;
					end
					if (head_q == t_node) begin
						head_d = nx_rd;
					end
					if (tail_q == t_node) begin
						tail_d = pv_rd;
					end
					count_d = count_q - COUNT_W'(1);
					if (op_q != OP_REMOVE) begin
						popped_d   = to_node(t_node);
						popped_v_d = 1'b1;
					end
				end
			end
			OP_QUERY: begin
				if (n_ok_q) begin
					qn_d   = to_node(nx_rd);
					qn_v_d = is_slot(nx_rd);
					qp_d   = to_node(pv_rd);
					qp_v_d = is_slot(pv_rd);
				end
			end
		endcase
	end

	// write port select: clearing pass, first or second write cycle
	always_comb begin
		nx_we = 1'b0;
		nx_wa = clr_q;
		nx_wd = NIL;
		pv_we = 1'b0;
		pv_wa = clr_q;
		pv_wd = NIL;
		unique case (state_q)
			ST_CLEAR: begin
				nx_we = 1'b1;
				pv_we = 1'b1;
			end
			ST_W1: begin
				nx_we = w1_nx_we;
				nx_wa = w1_nx_wa;
				nx_wd = w1_nx_wd;
				pv_we = w1_pv_we;
				pv_wa = w1_pv_wa;
				pv_wd = w1_pv_wd;
			end
			ST_W2: begin
				nx_we = w2_nx_we_q;
				nx_wa = w2_nx_wa_q;
				nx_wd = w2_nx_wd_q;
				pv_we = w2_pv_we_q;
				pv_wa = w2_pv_wa_q;
				pv_wd = w2_pv_wd_q;
			end
			default: begin
				nx_we = 1'b0;
				pv_we = 1'b0;
			end
		endcase
	end

	dllm_link_ram #(
		.DEPTH (NODES),
		.WIDTH (LW)
	) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_wa),
		.wdata (nx_wd),
		.re    (take),
		.raddr (nx_ra),
		.rdata (nx_rd)
	);

	dllm_link_ram #(
		.DEPTH (NODES),
		.WIDTH (LW)
	) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_wa),
		.wdata (pv_wd),
		.re    (take),
		.raddr (pv_ra),
		.rdata (pv_rd)
	);

	// sequencer, list pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			head_q      <= NIL;
			tail_q      <= NIL;
			count_q     <= '0;
			op_q        <= OP_QUERY;
			n_q         <= NIL;
			a_q         <= NIL;
			n_ok_q      <= 1'b0;
			a_ok_q      <= 1'b0;
			w2_nx_we_q  <= 1'b0;
			w2_nx_wa_q  <= '0;
			w2_nx_wd_q  <= NIL;
			w2_pv_we_q  <= 1'b0;
			w2_pv_wa_q  <= '0;
			w2_pv_wd_q  <= NIL;
			popped_q    <= '0;
			popped_v_q  <= 1'b0;
			qn_q        <= '0;
			qn_v_q      <= 1'b0;
			qp_q        <= '0;
			qp_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
			popped_node  <= '0;
			popped_valid <= 1'b0;
			head_node    <= '0;
			tail_node    <= '0;
			list_empty   <= 1'b1;
			count        <= '0;
			next_node    <= '0;
			next_valid   <= 1'b0;
			prev_node    <= '0;
			prev_valid   <= 1'b0;
		end else begin
			// result leaves; in ST_DONE the load below decides the flag
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= op_in;
						n_q     <= node_l;
						a_q     <= anchor_l;
						n_ok_q  <= n_ok_in;
						a_ok_q  <= a_ok_in;
						state_q <= ST_W1;
					end
				end
				ST_W1: begin
					head_q     <= head_d;
					tail_q     <= tail_d;
					count_q    <= count_d;
					w2_nx_we_q <= w2_nx_we;
					w2_nx_wa_q <= w2_nx_wa;
					w2_nx_wd_q <= w2_nx_wd;
					w2_pv_we_q <= w2_pv_we;
					w2_pv_wa_q <= w2_pv_wa;
					w2_pv_wd_q <= w2_pv_wd;
					popped_q   <= popped_d;
					popped_v_q <= popped_v_d;
					qn_q       <= qn_d;
					qn_v_q     <= qn_v_d;
					qp_q       <= qp_d;
					qp_v_q     <= qp_v_d;
					state_q    <= ST_W2;
				end
				ST_W2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						popped_node  <= popped_q;
						popped_valid <= popped_v_q;
						head_node    <= to_node(head_q);
						tail_node    <= to_node(tail_q);
						list_empty   <= !is_slot(head_q);
						count        <= count_q;
						next_node    <= qn_q;
						next_valid   <= qn_v_q;
						prev_node    <= qp_q;
						prev_valid   <= qp_v_q;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
